/* hdl/pmsfp_pkg.sv */
// Shared types and constants for the particulate sensor frame parser.
package pmsfp_pkg;

  // Default frame length in bytes, header and checksum included
  localparam int unsigned FRAME_BYTES_DEFAULT = 24;

  // Frame byte positions of the big-endian level words
  localparam int unsigned PM_FIRST_BYTE = 10;
  localparam int unsigned PM_LAST_BYTE  = 15;

  // Reset values of the header registers
  localparam logic [7:0] HEADER_FIRST_RESET  = 8'd66;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'd77;

  // Register index taken from paddr[2]
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam int unsigned LEVEL_COUNT = 3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SUM    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  // One result from the parser, valid for the current input beat
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] pm1_value;
    logic [15:0] pm2_5_value;
    logic [15:0] pm10_value;
  } result_t;

endpackage

/* hdl/pmsfp_in_if.sv */
// Input byte channel of the frame parser.
interface pmsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_gap;

  modport source (output valid, output rx_byte, output line_gap, input ready);
  modport sink (input valid, input rx_byte, input line_gap, output ready);
endinterface

/* hdl/pmsfp_out_if.sv */
// Result channel of the frame parser.
interface pmsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pm1_value;
  logic [15:0] pm2_5_value;
  logic [15:0] pm10_value;

  modport source (output valid, output status, output pm1_value, output pm2_5_value,
                  output pm10_value, input ready);
  modport sink (input valid, input status, input pm1_value, input pm2_5_value,
                input pm10_value, output ready);
endinterface

/* hdl/pm_sensor_frame_parser_core.sv */
// Particulate sensor frame parser: top level with APB registers and result register.
// The result is registered: it is on the output in the cycle after the beat that completes or aborts it.
// Throughput: one input beat per cycle; the input stalls only while a result waits unread.
// Reset (rst, synchronous, active high): parser hunts for a header, sum and levels zero,
// header registers return to 66 and 77, no result pending.
module pm_sensor_frame_parser_core #(
  parameter int unsigned FRAME_BYTES = pmsfp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  pmsfp_in_if.sink    in_ch,
  pmsfp_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]         header_first;
  logic [7:0]         header_second;
  logic               in_fire;
  logic               cfg_write;
  pmsfp_pkg::result_t result;

  logic               out_valid;
  logic [1:0]         out_status;
  logic [15:0]        out_pm1;
  logic [15:0]        out_pm2_5;
  logic [15:0]        out_pm10;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= pmsfp_pkg::HEADER_FIRST_RESET;
      header_second <= pmsfp_pkg::HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        pmsfp_pkg::REG_HEADER_FIRST:  header_first  <= pwdata[7:0];
        pmsfp_pkg::REG_HEADER_SECOND: header_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pmsfp_pkg::REG_HEADER_FIRST:  prdata = {24'h0, header_first};
      pmsfp_pkg::REG_HEADER_SECOND: prdata = {24'h0, header_second};
      default:                      prdata = '0;
    endcase
  end

  // Input handshake: take a beat whenever the result register is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  pmsfp_parse #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .rx_byte       (in_ch.rx_byte),
    .line_gap      (in_ch.line_gap),
    .header_first  (header_first),
    .header_second (header_second),
    .result        (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.valid) begin
      out_status <= result.status;
      out_pm1    <= result.pm1_value;
      out_pm2_5  <= result.pm2_5_value;
      out_pm10   <= result.pm10_value;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.pm1_value   = out_pm1;
  assign out_ch.pm2_5_value = out_pm2_5;
  assign out_ch.pm10_value  = out_pm10;

endmodule

/* hdl/pmsfp_parse.sv */
// Frame tracking state: header hunt, byte count, running sum and level capture.
module pmsfp_parse #(
  parameter int unsigned FRAME_BYTES = pmsfp_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          rx_byte,
  input  logic                line_gap,
  input  logic [7:0]          header_first,
  input  logic [7:0]          header_second,
  output pmsfp_pkg::result_t  result
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] PosCkHigh = PosW'(FRAME_BYTES - 2);
  localparam logic [PosW-1:0] PosPmFirst = PosW'(pmsfp_pkg::PM_FIRST_BYTE);
  localparam logic [PosW-1:0] PosPmLast = PosW'(pmsfp_pkg::PM_LAST_BYTE);
  localparam logic [PosW-1:0] PosOne = PosW'(1);
  localparam logic [PosW-1:0] PosTwo = PosW'(2);

  logic [PosW-1:0] byte_position, byte_position_next;
  logic [15:0]     running_sum, running_sum_next;
  logic [15:0]     levels [pmsfp_pkg::LEVEL_COUNT];
  logic [15:0]     levels_next [pmsfp_pkg::LEVEL_COUNT];
  logic [7:0]      checksum_high_byte, checksum_high_byte_next;

  logic [15:0]     sum_add;
  logic [PosW-1:0] pm_offset;
  logic [1:0]      level_idx;

  assign sum_add   = running_sum + {8'h00, rx_byte};
  assign pm_offset = byte_position - PosPmFirst;
  assign level_idx = pm_offset[2:1];

  // Next state and result for the byte at the input
  always_comb begin
    byte_position_next      = byte_position;
    running_sum_next        = running_sum;
    levels_next             = levels;
    checksum_high_byte_next = checksum_high_byte;
    result.valid            = 1'b0;
    result.status           = pmsfp_pkg::ST_OK;
    result.pm1_value        = levels[0];
    result.pm2_5_value      = levels[1];
    result.pm10_value       = levels[2];

    if (line_gap) begin
      // abort a partial frame; ignored while hunting
      if (byte_position != '0) begin
        byte_position_next = '0;
        running_sum_next   = '0;
        result.valid       = 1'b1;
        result.status      = pmsfp_pkg::ST_INCOMPLETE;
        result.pm1_value   = '0;
        result.pm2_5_value = '0;
        result.pm10_value  = '0;
      end
    end else if (byte_position == '0 ||
                 (byte_position == PosOne && rx_byte != header_second)) begin
      // hunt: a failed second header byte is retried as a first one
      if (rx_byte == header_first) begin
        byte_position_next = PosOne;
        running_sum_next   = {8'h00, rx_byte};
      end else begin
        byte_position_next = '0;
        running_sum_next   = '0;
      end
    end else if (byte_position == PosOne) begin
      byte_position_next = PosTwo;
      running_sum_next   = sum_add;
    end else if (byte_position < PosCkHigh) begin
      running_sum_next   = sum_add;
      byte_position_next = byte_position + PosOne;
      if (byte_position >= PosPmFirst && byte_position <= PosPmLast) begin
        if (!pm_offset[0]) begin
          levels_next[level_idx] = {rx_byte, 8'h00};
        end else begin
          levels_next[level_idx] = {levels[level_idx][15:8], rx_byte};
        end
      end
    end else if (byte_position == PosCkHigh) begin
      checksum_high_byte_next = rx_byte;
      byte_position_next      = byte_position + PosOne;
    end else begin
      // last byte: check the sum and report the frame
      result.valid       = 1'b1;
      result.status      = ({checksum_high_byte, rx_byte} == running_sum) ?
                           pmsfp_pkg::ST_OK : pmsfp_pkg::ST_BAD_SUM;
      byte_position_next = '0;
      running_sum_next   = '0;
    end
  end

  // State update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      running_sum        <= '0;
      levels             <= '{default: '0};
      checksum_high_byte <= '0;
    end else if (in_fire) begin
      byte_position      <= byte_position_next;
      running_sum        <= running_sum_next;
      levels             <= levels_next;
      checksum_high_byte <= checksum_high_byte_next;
    end
  end

endmodule
